/* src/nfd_pkg.sv */
// ----------------------------------------------------------------------------
// nfd_pkg: shared definitions for the notification frame deframer
// Store geometry, preamble and command codes, frame kinds, controller to
// datapath command and status bundles, and small helper functions.
// ----------------------------------------------------------------------------
package nfd_pkg;

  // Reassembly store geometry.
  localparam int STORE_BYTES = 64;
  localparam int AW          = $clog2(STORE_BYTES);
  localparam int CW          = $clog2(STORE_BYTES + 1);

  // Framing constants.
  localparam logic [7:0] PREAMBLE_BYTE      = 8'hFE;
  localparam int         STATUS_MIN_PAYLOAD = 18;
  localparam int         DUAL_MIN_PAYLOAD   = 30;

  // Command codes.
  localparam logic [7:0] CMD_LINK   = 8'h00;
  localparam logic [7:0] CMD_STATUS = 8'h01;
  localparam logic [7:0] CMD_SET_A  = 8'h02;
  localparam logic [7:0] CMD_SET_B  = 8'h05;
  localparam logic [7:0] CMD_SET_C  = 8'h06;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_STATUS    = 2'd0;
  localparam kind_t KIND_BIND      = 2'd1;
  localparam kind_t KIND_SET       = 2'd2;
  localparam kind_t KIND_UNHANDLED = 2'd3;

  // Read address selection.
  typedef logic [1:0] rd_sel_t;

  localparam rd_sel_t RD_SCAN = 2'd0;
  localparam rd_sel_t RD_LEN  = 2'd1;
  localparam rd_sel_t RD_BODY = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    ovf_clr;
    logic    walk_init;
    logic    scan_step;
    logic    set_head;
    logic    no_pair;
    logic    len_ld;
    logic    emit;
    logic    frame_done;
    logic    finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ovf;
    logic scan_done;
    logic pair_hit;
    logic too_short;
    logic frame_short;
    logic len_zero;
    logic last_byte;
    logic pend_v;
    logic out_free;
  } sts_t;

  // One result item.
  typedef struct packed {
    logic                       flast;
    logic                       dz;
    logic                       sc;
    kind_t                      kind;
    logic [5:0]                 off;
    logic [7:0]                 data;
  } res_t;

  // Classify a frame by its command byte.
  function automatic kind_t classify(input logic [7:0] cmd);
    kind_t k;
    if (cmd == CMD_STATUS) begin
      k = KIND_STATUS;
    end else if (cmd == CMD_LINK) begin
      k = KIND_BIND;
    end else if (cmd inside {CMD_SET_A, CMD_SET_B, CMD_SET_C}) begin
      k = KIND_SET;
    end else begin
      k = KIND_UNHANDLED;
    end
    return k;
  endfunction

  // Circular store address: base plus an offset, wrapped once.
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + (AW+1)'(off);
    if (s >= (AW+1)'(STORE_BYTES)) begin
      s = s - (AW+1)'(STORE_BYTES);
    end
    return s[AW-1:0];
  endfunction

endpackage

/* src/nfd_ctrl.sv */
// ----------------------------------------------------------------------------
// nfd_ctrl: deframer controller
// Sequences the store walk after each notification end: preamble hunt,
// length check, byte emission and final store compaction, or clears an overflowed store.
// ----------------------------------------------------------------------------
module nfd_ctrl
  import nfd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_acc,
  input  logic in_end,
  input  sts_t sts,
  output logic in_rdy,
  output cmd_t cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CHECK   = 4'd1;
  localparam logic [3:0] S_SCAN    = 4'd2;
  localparam logic [3:0] S_SCAN_EV = 4'd3;
  localparam logic [3:0] S_LEN_CHK = 4'd4;
  localparam logic [3:0] S_LEN_EV  = 4'd5;
  localparam logic [3:0] S_EM_RD   = 4'd6;
  localparam logic [3:0] S_EM_EV   = 4'd7;
  localparam logic [3:0] S_FR_DONE = 4'd8;
  localparam logic [3:0] S_FIN     = 4'd9;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_rdy = (state_r == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_sel = RD_SCAN;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_end) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.ovf) begin
          cmd.ovf_clr = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          cmd.walk_init = 1'b1;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          cmd.no_pair = 1'b1;
          state_nxt   = S_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_SCAN;
          state_nxt  = S_SCAN_EV;
        end
      end
      S_SCAN_EV: begin
        if (sts.pair_hit) begin
          cmd.set_head = 1'b1;
          state_nxt    = S_LEN_CHK;
        end else begin
          cmd.scan_step = 1'b1;
          state_nxt     = S_SCAN;
        end
      end
      S_LEN_CHK: begin
        if (sts.too_short) begin
          state_nxt = S_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_LEN;
          state_nxt  = S_LEN_EV;
        end
      end
      S_LEN_EV: begin
        cmd.len_ld = 1'b1;
        if (sts.frame_short) begin
          state_nxt = S_FIN;
        end else if (sts.len_zero) begin
          state_nxt = S_FR_DONE;
        end else begin
          state_nxt = S_EM_RD;
        end
      end
      S_EM_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_BODY;
        state_nxt  = S_EM_EV;
      end
      S_EM_EV: begin
        // Wait while the held result cannot move to the output register.
        if (!sts.pend_v || sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.last_byte ? S_FR_DONE : S_EM_RD;
        end
      end
      S_FR_DONE: begin
        cmd.frame_done = 1'b1;
        state_nxt      = S_SCAN;
      end
      S_FIN: begin
        if (!sts.pend_v || sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* src/nfd_dpath.sv */
// ----------------------------------------------------------------------------
// nfd_dpath: deframer datapath
// Circular reassembly store, walk pointers, frame length and kind registers,
// a one-result hold stage that learns the run end, and the output register.
// ----------------------------------------------------------------------------
module nfd_dpath
  import nfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_acc,
  input  logic [7:0]  in_byte,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic        out_valid,
  input  logic        out_ready,
  output res_t        out_res,
  output logic        out_rlast
);

  logic [7:0]    mem [STORE_BYTES];
  logic [7:0]    rd_data_r;
  logic [CW-1:0] fill_r;
  logic [AW-1:0] base_r;
  logic          ovf_r;
  logic [CW-1:0] head_r;
  logic [CW-1:0] ptr_r;
  logic          prev_fe_r;
  logic [7:0]    len_r;
  logic [7:0]    k_r;
  kind_t         kind_r;
  res_t          pend_r;
  logic          pend_v_r;
  res_t          out_res_r;
  logic          out_rlast_r;
  logic          out_valid_r;

  logic [CW-1:0] rd_off;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_en;
  logic [CW-1:0] avail;
  logic [CW-1:0] next_head;
  kind_t         kind_now;
  res_t          res_new;
  logic          push;
  logic          out_free;

  // Read offset relative to the current store base.
  always_comb begin
    case (cmd.rd_sel)
      RD_SCAN: rd_off = ptr_r;
      RD_LEN:  rd_off = head_r + CW'(2);
      RD_BODY: rd_off = head_r + CW'(3) + CW'(k_r);
      default: rd_off = ptr_r;
    endcase
  end

  assign rd_addr = wrap_add(base_r, rd_off);
  assign wr_addr = wrap_add(base_r, fill_r);
  assign wr_en   = in_acc && (fill_r != CW'(STORE_BYTES));

  // Store: one write port for arriving bytes, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_byte;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Fill level, base and overflow flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      base_r <= '0;
      ovf_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        if (fill_r == CW'(STORE_BYTES)) begin
          ovf_r <= 1'b1;
        end else begin
          fill_r <= fill_r + CW'(1);
        end
      end else if (cmd.ovf_clr) begin
        fill_r <= '0;
        ovf_r  <= 1'b0;
      end else if (cmd.finish) begin
        base_r <= wrap_add(base_r, head_r);
        fill_r <= fill_r - head_r;
      end
    end
  end

  assign next_head = head_r + CW'(3) + CW'(len_r);

  // Walk pointers and frame registers.
  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      head_r    <= '0;
      ptr_r     <= '0;
      prev_fe_r <= 1'b0;
    end
    if (cmd.scan_step) begin
      prev_fe_r <= (rd_data_r == PREAMBLE_BYTE);
      ptr_r     <= ptr_r + CW'(1);
    end
    if (cmd.set_head) begin
      head_r <= ptr_r - CW'(1);
    end
    if (cmd.no_pair) begin
      head_r <= fill_r;
    end
    if (cmd.len_ld) begin
      len_r <= rd_data_r;
      k_r   <= '0;
    end
    if (cmd.emit) begin
      k_r <= k_r + 8'd1;
      if (k_r == 8'd0) begin
        kind_r <= kind_now;
      end
    end
    if (cmd.frame_done) begin
      head_r    <= next_head;
      ptr_r     <= next_head;
      prev_fe_r <= 1'b0;
    end
  end

  // The command byte sets the kind of the whole frame.
  assign kind_now = (k_r == 8'd0) ? classify(rd_data_r) : kind_r;

  always_comb begin
    res_new.data  = rd_data_r;
    res_new.off   = k_r[5:0];
    res_new.kind  = kind_now;
    res_new.sc    = (kind_now == KIND_STATUS) && (len_r >= 8'(STATUS_MIN_PAYLOAD + 1));
    res_new.dz    = (kind_now == KIND_STATUS) && (len_r >= 8'(DUAL_MIN_PAYLOAD + 1));
    res_new.flast = ({1'b0, k_r} + 9'd1) == {1'b0, len_r};
  end

  // Hold stage: a result moves on once the next one, or the walk end, is known.
  assign out_free = !out_valid_r || out_ready;
  assign push     = (cmd.emit || cmd.finish) && pend_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else if (cmd.emit) begin
      pend_v_r <= 1'b1;
    end else if (cmd.finish) begin
      pend_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pend_r <= res_new;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_res_r   <= pend_r;
      out_rlast_r <= cmd.finish;
    end
  end

  assign avail = fill_r - head_r;

  // Status towards the controller.
  always_comb begin
    sts.ovf         = ovf_r;
    sts.scan_done   = (ptr_r >= fill_r);
    sts.pair_hit    = prev_fe_r && (rd_data_r == PREAMBLE_BYTE);
    sts.too_short   = (avail < CW'(3));
    sts.frame_short = (9'(avail) < (9'd3 + {1'b0, rd_data_r}));
    sts.len_zero    = (rd_data_r == 8'd0);
    sts.last_byte   = res_new.flast;
    sts.pend_v      = pend_v_r;
    sts.out_free    = out_free;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign out_rlast = out_rlast_r;

endmodule

/* src/notify_frame_deframer_core.sv */
// Input: a byte without notification end is taken while idle and the next may
// follow at once. A notification end starts a store walk that scans and emits
// bytes one at a time through the single read port and waits on output stalls;
// no input is taken until the walk ends.
// A result leaves the hold stage when the next is emitted or the walk ends.
// Reset is synchronous, active low, and empties the store and the output.
// ----------------------------------------------------------------------------
// notify_frame_deframer_core: notification frame deframer, top level
// Reassembles received bytes, hunts for the two-byte preamble, checks the
// length and streams out each complete frame's command and body bytes with
// their classification.
// ----------------------------------------------------------------------------
module notify_frame_deframer_core
  import nfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tlast,   // notification_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] frame_byte, [13:8] byte_offset, rest zero
  output logic [4:0]  out_tuser,  // [1:0] frame_kind, [2] status_complete,
                                  // [3] two-zone flag, [4] frame_last
  output logic        out_tlast   // run_last
);

  logic in_acc;
  cmd_t cmd;
  sts_t sts;
  res_t out_res;
  logic out_rlast;

  assign in_acc = in_tvalid && in_tready;

  nfd_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_acc (in_acc),
    .in_end (in_tlast),
    .sts    (sts),
    .in_rdy (in_tready),
    .cmd    (cmd)
  );

  nfd_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_acc    (in_acc),
    .in_byte   (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res),
    .out_rlast (out_rlast)
  );

  // Pack the result transfer.
  assign out_tdata = {2'b00, out_res.off, out_res.data};
  assign out_tuser = {out_res.flast, out_res.dz, out_res.sc, out_res.kind};
  assign out_tlast = out_rlast;

endmodule
